// ===== design/pbsp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the BAR sizing probe.
// Used by pbsp_decode, pbsp_result_fifo and pci_bar_size_probe; no dependencies.
package pbsp_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0]  BAR_BASE_OFFSET = 8'h10;
  localparam logic [31:0] ALL_ONES        = 32'hFFFF_FFFF;
  localparam logic [31:0] MEM_FLAG_MASK   = 32'hFFFF_FFF0;
  localparam logic [31:0] IO_FLAG_MASK    = 32'hFFFF_FFFC;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ORIG = 3'd1,
    PH_MASK = 3'd2,
    PH_OHI  = 3'd3,
    PH_MHI  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    RK_READ   = 2'd0,
    RK_WRITE  = 2'd1,
    RK_RECORD = 2'd2
  } result_kind_t;

  typedef enum logic [1:0] {
    CFG_BUS      = 2'd0,
    CFG_DEVICE   = 2'd1,
    CFG_FUNCTION = 2'd2
  } cfg_index_t;

  typedef enum logic {
    KIND_START      = 1'b0,
    KIND_COMPLETION = 1'b1
  } item_kind_t;

  typedef struct packed {
    logic [7:0] bus;
    logic [4:0] device;
    logic [2:0] function_num;
  } target_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] cfg_address;
    logic [31:0] write_data;
    logic [63:0] bar_base;
    logic [63:0] bar_size;
    logic        is_io;
    logic        is_wide;
    logic        prefetchable;
    logic        bar_valid;
    logic [1:0]  slots_used;
    logic        last;
  } result_t;

  function automatic logic [31:0] make_addr(target_t tgt, logic [7:0] off);
    make_addr = {1'b1, 7'b0, tgt.bus, tgt.device, tgt.function_num, off[7:2], 2'b00};
  endfunction

  function automatic result_t make_req(result_kind_t k, logic [31:0] addr,
                                       logic [31:0] data, logic lst);
    result_t r;
    r             = '0;
    r.result_kind = k;
    r.cfg_address = addr;
    r.write_data  = data;
    r.last        = lst;
    make_req      = r;
  endfunction

endpackage

// ===== design/pci_bar_size_probe.sv =====
`timescale 1ns / 1ps
// BAR sizing probe top level: target registers, an input stage register, the
// sequencer and the result queue. A beat is registered in the stage and its results
// are then registered in the queue. Input beats are taken one per cycle while the
// queue has room; the output gives one result per cycle while res_ready is high.
// Reset clears the phase, captured dwords, queue and target registers to zero.
module pci_bar_size_probe (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        kind,
  input  logic [2:0]  bar_index,
  input  logic [31:0] read_data,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [1:0]  result_kind,
  output logic [31:0] cfg_address,
  output logic [31:0] write_data,
  output logic [63:0] bar_base,
  output logic [63:0] bar_size,
  output logic        is_io,
  output logic        is_wide,
  output logic        prefetchable,
  output logic        bar_valid,
  output logic [1:0]  slots_used,
  output logic        last
);

  pbsp_pkg::target_t target;
  logic              stg_valid;
  logic              stg_kind;
  logic [2:0]        stg_index;
  logic [31:0]       stg_data;
  logic              room;
  logic              advance;
  logic [1:0]        dec_count;
  logic [1:0]        push_count;
  pbsp_pkg::result_t dec_r0;
  pbsp_pkg::result_t dec_r1;
  pbsp_pkg::result_t head;

  assign cfg_ready  = 1'b1;
  assign advance    = stg_valid && room;
  assign item_ready = !stg_valid || room;
  assign push_count = advance ? dec_count : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pbsp_pkg::CFG_BUS:      target.bus          <= cfg_data;
        pbsp_pkg::CFG_DEVICE:   target.device       <= cfg_data[4:0];
        pbsp_pkg::CFG_FUNCTION: target.function_num <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      stg_valid <= 1'b1;
    end else if (advance) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stg_kind  <= kind;
      stg_index <= bar_index;
      stg_data  <= read_data;
    end
  end

  pbsp_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .go           (advance),
    .kind         (stg_kind),
    .bar_index    (stg_index),
    .read_data    (stg_data),
    .target       (target),
    .result_count (dec_count),
    .result0      (dec_r0),
    .result1      (dec_r1)
  );

  pbsp_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (dec_r0),
    .push1      (dec_r1),
    .room       (room),
    .head_valid (res_valid),
    .head_pop   (res_ready),
    .head       (head)
  );

  assign result_kind  = head.result_kind;
  assign cfg_address  = head.cfg_address;
  assign write_data   = head.write_data;
  assign bar_base     = head.bar_base;
  assign bar_size     = head.bar_size;
  assign is_io        = head.is_io;
  assign is_wide      = head.is_wide;
  assign prefetchable = head.prefetchable;
  assign bar_valid    = head.bar_valid;
  assign slots_used   = head.slots_used;
  assign last         = head.last;

endmodule

// ===== design/pbsp_decode.sv =====
`timescale 1ns / 1ps
// Probe sequencer: holds the sizing phase and captured dwords and turns one
// staged beat into up to two result records. Depends on pbsp_pkg.
module pbsp_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic              kind,
  input  logic [2:0]        bar_index,
  input  logic [31:0]       read_data,
  input  pbsp_pkg::target_t target,
  output logic [1:0]        result_count,
  output pbsp_pkg::result_t result0,
  output pbsp_pkg::result_t result1
);

  pbsp_pkg::phase_t phase;
  pbsp_pkg::phase_t phase_next;
  logic [7:0]       bar_offset;
  logic [31:0]      orig_low;
  logic [31:0]      mask_low;
  logic [31:0]      orig_high;

  logic [7:0]  start_offset;
  logic [7:0]  hi_off;
  logic [31:0] lo_addr;
  logic [31:0] hi_addr;
  logic [31:0] io_size;
  logic [63:0] mem_size;
  logic [63:0] wide_size;
  logic [63:0] hi_mask_size;
  logic [31:0] mask_mem;
  logic [31:0] orig_mem;

  assign start_offset = {3'b0, bar_index, 2'b00} + pbsp_pkg::BAR_BASE_OFFSET;
  assign hi_off       = bar_offset + 8'd4;
  assign lo_addr      = pbsp_pkg::make_addr(target, bar_offset);
  assign hi_addr      = pbsp_pkg::make_addr(target, hi_off);
  assign io_size      = ~(read_data & pbsp_pkg::IO_FLAG_MASK) + 32'd1;
  assign mask_mem     = read_data & pbsp_pkg::MEM_FLAG_MASK;
  assign orig_mem     = orig_low & pbsp_pkg::MEM_FLAG_MASK;
  assign mem_size     = {32'b0, ~mask_mem} + 64'd1;
  assign hi_mask_size = ~{read_data, mask_low & pbsp_pkg::MEM_FLAG_MASK} + 64'd1;
  assign wide_size    = (read_data != pbsp_pkg::ALL_ONES) ? hi_mask_size
                      : ({32'b0, ~(mask_low & pbsp_pkg::MEM_FLAG_MASK)} + 64'd1);

  always_comb begin
    phase_next = phase;
    if (kind == pbsp_pkg::KIND_START) begin
      if (phase == pbsp_pkg::PH_IDLE) begin
        phase_next = pbsp_pkg::PH_ORIG;
      end
    end else begin
      unique case (phase)
        pbsp_pkg::PH_ORIG: begin
          phase_next = (read_data == 32'd0) ? pbsp_pkg::PH_IDLE : pbsp_pkg::PH_MASK;
        end
        pbsp_pkg::PH_MASK: begin
          phase_next = (orig_low[0] == 1'b0 && orig_low[2:1] == 2'b10)
                     ? pbsp_pkg::PH_OHI : pbsp_pkg::PH_IDLE;
        end
        pbsp_pkg::PH_OHI: phase_next = pbsp_pkg::PH_MHI;
        pbsp_pkg::PH_MHI: phase_next = pbsp_pkg::PH_IDLE;
        default:          phase_next = pbsp_pkg::PH_IDLE;
      endcase
    end
  end

  always_comb begin
    result_count = 2'd0;
    result0      = '0;
    result1      = '0;
    if (kind == pbsp_pkg::KIND_START) begin
      if (phase == pbsp_pkg::PH_IDLE) begin
        result_count = 2'd1;
        result0 = pbsp_pkg::make_req(pbsp_pkg::RK_READ,
                                     pbsp_pkg::make_addr(target, start_offset), 32'd0, 1'b1);
      end
    end else begin
      unique case (phase)
        pbsp_pkg::PH_ORIG: begin
          if (read_data == 32'd0) begin
            result_count       = 2'd1;
            result0.result_kind = pbsp_pkg::RK_RECORD;
            result0.slots_used  = 2'd1;
            result0.last        = 1'b1;
          end else begin
            result_count = 2'd2;
            result0 = pbsp_pkg::make_req(pbsp_pkg::RK_WRITE, lo_addr, pbsp_pkg::ALL_ONES, 1'b0);
            result1 = pbsp_pkg::make_req(pbsp_pkg::RK_READ, lo_addr, 32'd0, 1'b1);
          end
        end
        pbsp_pkg::PH_MASK: begin
          result_count = 2'd2;
          result0 = pbsp_pkg::make_req(pbsp_pkg::RK_WRITE, lo_addr, orig_low, 1'b0);
          if (orig_low[0]) begin
            result1.result_kind = pbsp_pkg::RK_RECORD;
            result1.bar_base    = {32'b0, orig_low & pbsp_pkg::IO_FLAG_MASK};
            result1.bar_size    = {32'b0, io_size};
            result1.is_io       = 1'b1;
            result1.bar_valid   = 1'b1;
            result1.slots_used  = 2'd1;
            result1.last        = 1'b1;
          end else if (orig_low[2:1] == 2'b10) begin
            result1 = pbsp_pkg::make_req(pbsp_pkg::RK_READ, hi_addr, 32'd0, 1'b1);
          end else begin
            result1.result_kind  = pbsp_pkg::RK_RECORD;
            result1.bar_base     = {32'b0, orig_mem};
            result1.bar_size     = mem_size;
            result1.prefetchable = orig_low[3];
            result1.bar_valid    = 1'b1;
            result1.slots_used   = 2'd1;
            result1.last         = 1'b1;
          end
        end
        pbsp_pkg::PH_OHI: begin
          result_count = 2'd2;
          result0 = pbsp_pkg::make_req(pbsp_pkg::RK_WRITE, hi_addr, pbsp_pkg::ALL_ONES, 1'b0);
          result1 = pbsp_pkg::make_req(pbsp_pkg::RK_READ, hi_addr, 32'd0, 1'b1);
        end
        pbsp_pkg::PH_MHI: begin
          result_count = 2'd2;
          result0 = pbsp_pkg::make_req(pbsp_pkg::RK_WRITE, hi_addr, orig_high, 1'b0);
          result1.result_kind  = pbsp_pkg::RK_RECORD;
          result1.bar_base     = {orig_high, orig_mem};
          result1.bar_size     = wide_size;
          result1.is_wide      = 1'b1;
          result1.prefetchable = orig_low[3];
          result1.bar_valid    = 1'b1;
          result1.slots_used   = 2'd2;
          result1.last         = 1'b1;
        end
        default: result_count = 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= pbsp_pkg::PH_IDLE;
      bar_offset <= 8'd0;
      orig_low   <= 32'd0;
      mask_low   <= 32'd0;
      orig_high  <= 32'd0;
    end else if (go) begin
      phase <= phase_next;
      if (kind == pbsp_pkg::KIND_START) begin
        if (phase == pbsp_pkg::PH_IDLE) begin
          bar_offset <= start_offset;
        end
      end else begin
        unique case (phase)
          pbsp_pkg::PH_ORIG: orig_low  <= read_data;
          pbsp_pkg::PH_MASK: mask_low  <= read_data;
          pbsp_pkg::PH_OHI:  orig_high <= read_data;
          default: ;
        endcase
      end
    end
  end

  a_idle_start_one_result: assert property (@(posedge clk) disable iff (rst)
    (kind == pbsp_pkg::KIND_START && phase == pbsp_pkg::PH_IDLE) |-> (result_count == 2'd1))
    else $error("start from idle must give exactly one read request");

  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    (result_count == 2'd2) |-> (!result0.last && result1.last))
    else $error("last flag misplaced in a two-result beat");

  a_wide_phase_path: assert property (@(posedge clk) disable iff (rst)
    (go && phase == pbsp_pkg::PH_OHI && kind == pbsp_pkg::KIND_COMPLETION)
      |=> (phase == pbsp_pkg::PH_MHI))
    else $error("high original dword did not advance to high mask phase");

endmodule

// ===== design/pbsp_result_fifo.sv =====
`timescale 1ns / 1ps
// Result queue: takes up to two records per cycle and hands out one per beat.
// Depends on pbsp_pkg.
module pbsp_result_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_count,
  input  pbsp_pkg::result_t push0,
  input  pbsp_pkg::result_t push1,
  output logic              room,
  output logic              head_valid,
  input  logic              head_pop,
  output pbsp_pkg::result_t head
);

  pbsp_pkg::result_t mem [pbsp_pkg::FIFO_DEPTH];
  logic [pbsp_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [pbsp_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [pbsp_pkg::FIFO_CNT_W-1:0] count;
  logic [pbsp_pkg::FIFO_CNT_W-1:0] count_next;
  logic                            pop;

  assign pop        = head_valid && head_pop;
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign room       = (count <= pbsp_pkg::FIFO_CNT_W'(pbsp_pkg::FIFO_DEPTH - 2));
  assign count_next = count + pbsp_pkg::FIFO_CNT_W'(push_count)
                    - pbsp_pkg::FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr + pbsp_pkg::FIFO_PTR_W'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + pbsp_pkg::FIFO_PTR_W'(push_count);
      rd_ptr <= rd_ptr + pbsp_pkg::FIFO_PTR_W'(pop);
      count  <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= pbsp_pkg::FIFO_CNT_W'(pbsp_pkg::FIFO_DEPTH))
    else $error("result queue count above depth");

  a_no_overflow_push: assert property (@(posedge clk) disable iff (rst)
    (push_count != 2'd0) |-> room)
    else $error("records pushed without room");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    ##1 (count == $past(count_next)))
    else $error("queue count did not follow pushes and pops");

endmodule

// ===== sim/pci_bar_size_probe_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pci_bar_size_probe: drives start and completion beats,
// predicts every request and BAR record, and checks them in order at the output.
// Depends on pbsp_pkg and the pci_bar_size_probe RTL.
module pci_bar_size_probe_tb;

  localparam int ITEM_TARGET = 900;
  localparam int QUIET_FROM  = ITEM_TARGET - 150;
  localparam int STALL_LIMIT = 1000;

  class bar_sizing_predictor;
    pbsp_pkg::phase_t  ph;
    logic [7:0]        bar_off;
    logic [31:0]       orig_lo;
    logic [31:0]       mask_lo;
    logic [31:0]       orig_hi;
    pbsp_pkg::target_t tgt;
    pbsp_pkg::result_t pending_results[$];
    int                useful;
    int                errors;

    function new();
      ph      = pbsp_pkg::PH_IDLE;
      bar_off = '0;
      orig_lo = '0;
      mask_lo = '0;
      orig_hi = '0;
      tgt     = '0;
      useful  = 0;
      errors  = 0;
    endfunction

    function void set_target(pbsp_pkg::cfg_index_t idx, logic [7:0] value);
      case (idx)
        pbsp_pkg::CFG_BUS:      tgt.bus = value;
        pbsp_pkg::CFG_DEVICE:   tgt.device = value[4:0];
        pbsp_pkg::CFG_FUNCTION: tgt.function_num = value[2:0];
        default: ;
      endcase
    endfunction

    function void add_request(pbsp_pkg::result_kind_t k, logic [7:0] off,
                              logic [31:0] data, logic lst);
      pbsp_pkg::result_t r;
      r             = '0;
      r.result_kind = k;
      r.cfg_address = {1'b1, 7'h00, tgt.bus, tgt.device, tgt.function_num,
                       off & 8'hFC};
      r.write_data  = data;
      r.last        = lst;
      pending_results.push_back(r);
    endfunction

    function void add_record(logic [63:0] base, logic [63:0] size, logic io,
                             logic wide, logic pf, logic valid, logic [1:0] slots);
      pbsp_pkg::result_t r;
      r              = '0;
      r.result_kind  = pbsp_pkg::RK_RECORD;
      r.bar_base     = base;
      r.bar_size     = size;
      r.is_io        = io;
      r.is_wide      = wide;
      r.prefetchable = pf;
      r.bar_valid    = valid;
      r.slots_used   = slots;
      r.last         = 1'b1;
      pending_results.push_back(r);
    endfunction

    function void note_item(pbsp_pkg::item_kind_t k, logic [2:0] idx, logic [31:0] d);
      logic [7:0]  hi_off;
      logic [31:0] inv_mask;
      logic [31:0] io_size;
      logic [63:0] size64;
      hi_off = bar_off + 8'd4;
      if (k == pbsp_pkg::KIND_START) begin
        if (ph != pbsp_pkg::PH_IDLE) return;
        bar_off = pbsp_pkg::BAR_BASE_OFFSET + {3'b000, idx, 2'b00};
        ph      = pbsp_pkg::PH_ORIG;
        add_request(pbsp_pkg::RK_READ, bar_off, '0, 1'b1);
        useful++;
        return;
      end
      if (ph == pbsp_pkg::PH_IDLE) return;
      useful++;
      case (ph)
        pbsp_pkg::PH_ORIG: begin
          orig_lo = d;
          if (d == '0) begin
            add_record('0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 2'd1);
            ph = pbsp_pkg::PH_IDLE;
          end else begin
            add_request(pbsp_pkg::RK_WRITE, bar_off, pbsp_pkg::ALL_ONES, 1'b0);
            add_request(pbsp_pkg::RK_READ, bar_off, '0, 1'b1);
            ph = pbsp_pkg::PH_MASK;
          end
        end
        pbsp_pkg::PH_MASK: begin
          mask_lo  = d;
          inv_mask = ~(d & pbsp_pkg::MEM_FLAG_MASK);
          add_request(pbsp_pkg::RK_WRITE, bar_off, orig_lo, 1'b0);
          if (orig_lo[0]) begin
            io_size = ~(d & pbsp_pkg::IO_FLAG_MASK) + 32'd1;
            add_record({32'h0, orig_lo & pbsp_pkg::IO_FLAG_MASK}, {32'h0, io_size},
                       1'b1, 1'b0, 1'b0, 1'b1, 2'd1);
            ph = pbsp_pkg::PH_IDLE;
          end else if (orig_lo[2:1] == 2'b10) begin
            add_request(pbsp_pkg::RK_READ, hi_off, '0, 1'b1);
            ph = pbsp_pkg::PH_OHI;
          end else begin
            add_record({32'h0, orig_lo & pbsp_pkg::MEM_FLAG_MASK},
                       {32'h0, inv_mask} + 64'd1,
                       1'b0, 1'b0, orig_lo[3], 1'b1, 2'd1);
            ph = pbsp_pkg::PH_IDLE;
          end
        end
        pbsp_pkg::PH_OHI: begin
          orig_hi = d;
          add_request(pbsp_pkg::RK_WRITE, hi_off, pbsp_pkg::ALL_ONES, 1'b0);
          add_request(pbsp_pkg::RK_READ, hi_off, '0, 1'b1);
          ph = pbsp_pkg::PH_MHI;
        end
        pbsp_pkg::PH_MHI: begin
          inv_mask = ~(mask_lo & pbsp_pkg::MEM_FLAG_MASK);
          size64   = {32'h0, inv_mask} + 64'd1;
          if (d != pbsp_pkg::ALL_ONES) begin
            size64 = ~{d, mask_lo & pbsp_pkg::MEM_FLAG_MASK} + 64'd1;
          end
          add_request(pbsp_pkg::RK_WRITE, hi_off, orig_hi, 1'b0);
          add_record({orig_hi, orig_lo & pbsp_pkg::MEM_FLAG_MASK}, size64,
                     1'b0, 1'b1, orig_lo[3], 1'b1, 2'd2);
          ph = pbsp_pkg::PH_IDLE;
        end
        default: ph = pbsp_pkg::PH_IDLE;
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_field(string name, logic [63:0] got_v, logic [63:0] want_v);
      if (got_v !== want_v)
        report($sformatf("%s got %h, expected %h", name, got_v, want_v));
    endtask

    task check_result(pbsp_pkg::result_t got);
      pbsp_pkg::result_t want;
      if (pending_results.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      want = pending_results.pop_front();
      check_field("result_kind", 64'(got.result_kind), 64'(want.result_kind));
      check_field("cfg_address", 64'(got.cfg_address), 64'(want.cfg_address));
      check_field("write_data", 64'(got.write_data), 64'(want.write_data));
      check_field("bar_base", got.bar_base, want.bar_base);
      check_field("bar_size", got.bar_size, want.bar_size);
      check_field("is_io", 64'(got.is_io), 64'(want.is_io));
      check_field("is_wide", 64'(got.is_wide), 64'(want.is_wide));
      check_field("prefetchable", 64'(got.prefetchable), 64'(want.prefetchable));
      check_field("bar_valid", 64'(got.bar_valid), 64'(want.bar_valid));
      check_field("slots_used", 64'(got.slots_used), 64'(want.slots_used));
      check_field("last", 64'(got.last), 64'(want.last));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        item_valid;
  logic        item_ready;
  logic        kind;
  logic [2:0]  bar_index;
  logic [31:0] read_data;
  logic        res_valid;
  logic        res_ready;
  logic [1:0]  result_kind;
  logic [31:0] cfg_address;
  logic [31:0] write_data;
  logic [63:0] bar_base;
  logic [63:0] bar_size;
  logic        is_io;
  logic        is_wide;
  logic        prefetchable;
  logic        bar_valid;
  logic [1:0]  slots_used;
  logic        last;

  bar_sizing_predictor sb;
  bit hold_outputs = 1'b0;
  bit hold_done    = 1'b0;
  bit quiet        = 1'b0;
  bit calm         = 1'b0;
  int idle_cycles  = 0;

  pci_bar_size_probe dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .kind         (kind),
    .bar_index    (bar_index),
    .read_data    (read_data),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .result_kind  (result_kind),
    .cfg_address  (cfg_address),
    .write_data   (write_data),
    .bar_base     (bar_base),
    .bar_size     (bar_size),
    .is_io        (is_io),
    .is_wide      (is_wide),
    .prefetchable (prefetchable),
    .bar_valid    (bar_valid),
    .slots_used   (slots_used),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      sb.check_result({result_kind, cfg_address, write_data, bar_base, bar_size,
                       is_io, is_wide, prefetchable, bar_valid, slots_used, last});
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (res_valid && res_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // The long hold lets the result queue fill so that item_ready drops.
  initial begin
    forever begin
      if (hold_outputs) begin
        res_ready <= 1'b0;
        repeat (80) @(posedge clk);
        hold_outputs = 1'b0;
      end else if (quiet) begin
        res_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        res_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic send_item(pbsp_pkg::item_kind_t k, logic [2:0] idx, logic [31:0] d);
    item_valid <= 1'b1;
    kind       <= k;
    bar_index  <= idx;
    read_data  <= d;
    do @(posedge clk); while (item_ready !== 1'b1);
    sb.note_item(k, idx, d);
  endtask

  task automatic offer(pbsp_pkg::item_kind_t k, logic [2:0] idx, logic [31:0] d);
    if (!calm && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    send_item(k, idx, d);
  endtask

  task automatic write_reg(pbsp_pkg::cfg_index_t idx, logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_target(idx, value);
  endtask

  task automatic write_targets(logic [7:0] bus, logic [4:0] device, logic [2:0] fn);
    write_reg(pbsp_pkg::CFG_BUS, bus);
    write_reg(pbsp_pkg::CFG_DEVICE, {3'b000, device});
    write_reg(pbsp_pkg::CFG_FUNCTION, {5'b00000, fn});
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic settle();
    while (sb.ph != pbsp_pkg::PH_IDLE) begin
      send_item(pbsp_pkg::KIND_COMPLETION, 3'($urandom), $urandom);
    end
    drain();
  endtask

  function automatic logic [31:0] random_mask();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return pbsp_pkg::ALL_ONES;
      2: return '0;
      default: return ~((32'h1 << $urandom_range(2, 31)) - 32'h1);
    endcase
  endfunction

  task automatic run_probe(bit broken);
    logic [31:0] words[$];
    logic [31:0] orig;
    int n;
    calm = quiet || ($urandom_range(0, 3) == 0);
    orig = $urandom;
    case ($urandom_range(0, 9))
      0: orig = '0;
      1, 2: orig[0] = 1'b1;
      3, 4, 5: begin
        orig[0] = 1'b0;
        if (orig[2:1] == 2'b10) orig[2:1] = 2'b11;
      end
      default: orig[2:0] = 3'b100;
    endcase
    words.push_back(orig);
    if (orig != '0) begin
      words.push_back(random_mask());
      if (!orig[0] && orig[2:1] == 2'b10) begin
        words.push_back($urandom_range(0, 1) ? $urandom : 32'h0);
        words.push_back(random_mask());
      end
    end
    n = broken ? $urandom_range(0, words.size() - 1) : words.size();
    offer(pbsp_pkg::KIND_START, 3'($urandom), $urandom);
    for (int i = 0; i < n; i++) offer(pbsp_pkg::KIND_COMPLETION, 3'($urandom), words[i]);
  endtask

  initial begin
    int r;
    int setting;
    int next_cfg;
    sb         = new();
    rst        <= 1'b1;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    item_valid <= 1'b0;
    kind       <= 1'b0;
    bar_index  <= '0;
    read_data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_targets(8'h5A, 5'h15, 3'h2);

    offer(pbsp_pkg::KIND_COMPLETION, 3'd7, 32'hDEAD_BEEF);
    offer(pbsp_pkg::KIND_START, 3'd0, 32'h0);
    offer(pbsp_pkg::KIND_COMPLETION, 3'd0, 32'h0);
    offer(pbsp_pkg::KIND_START, 3'd5, 32'hFFFF_FFFF);
    offer(pbsp_pkg::KIND_START, 3'd2, 32'h0);
    offer(pbsp_pkg::KIND_COMPLETION, 3'd5, 32'hFFFF_FFFF);
    offer(pbsp_pkg::KIND_COMPLETION, 3'd5, 32'hFFFF_FFFF);
    offer(pbsp_pkg::KIND_START, 3'd7, 32'h0);
    offer(pbsp_pkg::KIND_COMPLETION, 3'd0, 32'h0000_0001);
    offer(pbsp_pkg::KIND_COMPLETION, 3'd0, 32'h0);
    offer(pbsp_pkg::KIND_START, 3'd6, 32'h0);
    offer(pbsp_pkg::KIND_COMPLETION, 3'd6, 32'hFFFF_FFF8);
    offer(pbsp_pkg::KIND_COMPLETION, 3'd6, 32'h0);
    offer(pbsp_pkg::KIND_START, 3'd1, 32'h0);
    offer(pbsp_pkg::KIND_COMPLETION, 3'd1, 32'hE000_0006);
    offer(pbsp_pkg::KIND_COMPLETION, 3'd1, 32'hFFFF_FFF0);
    offer(pbsp_pkg::KIND_START, 3'd3, 32'h0);
    offer(pbsp_pkg::KIND_COMPLETION, 3'd3, 32'h0000_000C);
    offer(pbsp_pkg::KIND_COMPLETION, 3'd3, 32'hFFFF_FFF0);
    offer(pbsp_pkg::KIND_COMPLETION, 3'd3, 32'hFFFF_FFFF);
    offer(pbsp_pkg::KIND_COMPLETION, 3'd3, 32'hFFFF_FFFF);
    offer(pbsp_pkg::KIND_START, 3'd4, 32'h0);
    offer(pbsp_pkg::KIND_COMPLETION, 3'd4, 32'hFFFF_FFF4);
    offer(pbsp_pkg::KIND_COMPLETION, 3'd4, 32'h0);
    offer(pbsp_pkg::KIND_COMPLETION, 3'd4, 32'h0);
    offer(pbsp_pkg::KIND_COMPLETION, 3'd4, 32'h0);
    settle();
    write_targets(8'hFF, 5'h1F, 3'h7);

    setting  = 0;
    next_cfg = 200;
    while (sb.useful < ITEM_TARGET) begin
      if (sb.useful >= QUIET_FROM) quiet = 1'b1;
      if (!hold_done && sb.useful >= 450) begin
        hold_outputs = 1'b1;
        hold_done    = 1'b1;
      end
      if (!quiet && sb.useful >= next_cfg) begin
        settle();
        case (setting)
          0: write_targets(8'h00, 5'h00, 3'h0);
          2: write_targets(8'hFF, 5'h1F, 3'h7);
          default: write_targets(8'($urandom), 5'($urandom), 3'($urandom));
        endcase
        setting++;
        next_cfg += 200;
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
        calm = quiet;
        offer(pbsp_pkg::item_kind_t'($urandom_range(0, 1)), 3'($urandom), $urandom);
      end else begin
        run_probe(r < 20);
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/pbsp_pkg.sv
design/pbsp_decode.sv
design/pbsp_result_fifo.sv
design/pci_bar_size_probe.sv
sim/pci_bar_size_probe_tb.sv
